### sv/assert_macros.svh
// assertion macros used by the rtl datapath module rrs_dp
// no dependencies; clock i_clk and active-low reset i_rst_n are assumed in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define RRS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the condition
`define RRS_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

### sv/rrs_pkg.sv
// package for the round-robin schedule simulator
// holds field widths, the default table depth and the controller/datapath command and status types
package rrs_pkg;

    localparam int MAX_PROCS_DEF = 16;

    localparam int BURST_W = 16;
    localparam int STAMP_W = 16;
    localparam int QUANT_W = 8;
    localparam int INDEX_W = 6;
    localparam int TIME_W  = 32;
    localparam int DIFF_W  = 33;
    localparam int SUM_W   = 40;
    localparam int OSUM_W  = 39;

    // commands from the controller
    typedef struct packed {
        logic load;       // store the accepted descriptor
        logic exec;       // run one slice of the current process
        logic turn;       // compute turnaround, mark done
        logic wait_step;  // compute wait, add turnaround to sum
        logic emit;       // load the output register
        logic advance;    // step the scan index
        logic clear;      // empty the batch
    } t_cmd;

    // status back to the controller
    typedef struct packed {
        logic cur_done;   // current process already finished
        logic rem_zero;   // current slice finishes the process
        logic last_done;  // every loaded process has finished
        logic out_free;   // output register can take an item
    } t_sts;

endpackage

### sv/round_robin_schedule_sim_core.sv
// round-robin schedule simulator: descriptors load at one item per cycle; the item marked
// last starts the run. an unfinished process's visit is a table read then a slice; a finished
// entry is skipped at its read; a completion adds turnaround, wait and emit steps, emit held
// by any output stall. no input item is taken during a run; results leave through a one-item
// output register. synchronous active-low reset clears control state, sets the quantum to 1;
// the tables need no clearing pass, only entries loaded in the current batch are ever read
module round_robin_schedule_sim_core #(
    parameter int MAX_PROCS = rrs_pkg::MAX_PROCS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 i_cfg_we,
    input  logic [rrs_pkg::QUANT_W-1:0]          i_cfg_wdata,
    // descriptor items
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [rrs_pkg::BURST_W-1:0]          i_burst_time,
    input  logic [rrs_pkg::STAMP_W-1:0]          i_arrival_stamp,
    input  logic                                 i_last_process,
    // completion items
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [rrs_pkg::INDEX_W-1:0]          o_proc_index,
    output logic [rrs_pkg::TIME_W-1:0]           o_start_time,
    output logic [rrs_pkg::TIME_W-1:0]           o_finish_time,
    output logic signed [rrs_pkg::DIFF_W-1:0]    o_turnaround,
    output logic signed [rrs_pkg::DIFF_W-1:0]    o_wait_ticks,
    output logic                                 o_final_result,
    output logic signed [rrs_pkg::OSUM_W-1:0]    o_turnaround_sum,
    output logic signed [rrs_pkg::OSUM_W-1:0]    o_wait_sum,
    output logic [rrs_pkg::TIME_W-1:0]           o_cpu_time
);

    // command and status between sequencer and datapath
    rrs_pkg::t_cmd cmd;
    rrs_pkg::t_sts sts;

    // sequencer: load, then read/slice per visit, then turnaround, wait, emit per completion
    rrs_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_last_process (i_last_process),
        .o_in_ready     (o_in_ready),
        .o_cmd          (cmd),
        .i_sts          (sts)
    );

    // tables, simulated clock, running sums and the output register
    rrs_dp #(
        .MAX_PROCS (MAX_PROCS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_burst_time     (i_burst_time),
        .i_arrival_stamp  (i_arrival_stamp),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_proc_index     (o_proc_index),
        .o_start_time     (o_start_time),
        .o_finish_time    (o_finish_time),
        .o_turnaround     (o_turnaround),
        .o_wait_ticks     (o_wait_ticks),
        .o_final_result   (o_final_result),
        .o_turnaround_sum (o_turnaround_sum),
        .o_wait_sum       (o_wait_sum),
        .o_cpu_time       (o_cpu_time)
    );

endmodule

### sv/rrs_ctrl.sv
// controller state machine for the round-robin schedule simulator
// depends on rrs_pkg (command and status types)
module rrs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_last_process,
    output logic          o_in_ready,
    output rrs_pkg::t_cmd o_cmd,
    input  rrs_pkg::t_sts i_sts
);

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_TURN = 3'd3;
    localparam logic [2:0] S_WAIT = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_last_process) begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                if (i_sts.cur_done) begin
                    o_cmd.advance = 1'b1;
                end else begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_sts.rem_zero) begin
                    n_state = S_TURN;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_READ;
                end
            end
            S_TURN: begin
                o_cmd.turn = 1'b1;
                n_state    = S_WAIT;
            end
            S_WAIT: begin
                o_cmd.wait_step = 1'b1;
                n_state         = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.last_done) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_LOAD;
                    end else begin
                        o_cmd.advance = 1'b1;
                        n_state       = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### sv/rrs_dp.sv
// datapath for the round-robin schedule simulator: tables, clock, sums, output register
// depends on rrs_pkg and assert_macros.svh
`include "assert_macros.svh"
module rrs_dp #(
    parameter int MAX_PROCS = rrs_pkg::MAX_PROCS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  rrs_pkg::t_cmd                        i_cmd,
    output rrs_pkg::t_sts                        o_sts,
    input  logic                                 i_cfg_we,
    input  logic [rrs_pkg::QUANT_W-1:0]          i_cfg_wdata,
    input  logic [rrs_pkg::BURST_W-1:0]          i_burst_time,
    input  logic [rrs_pkg::STAMP_W-1:0]          i_arrival_stamp,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic [rrs_pkg::INDEX_W-1:0]          o_proc_index,
    output logic [rrs_pkg::TIME_W-1:0]           o_start_time,
    output logic [rrs_pkg::TIME_W-1:0]           o_finish_time,
    output logic signed [rrs_pkg::DIFF_W-1:0]    o_turnaround,
    output logic signed [rrs_pkg::DIFF_W-1:0]    o_wait_ticks,
    output logic                                 o_final_result,
    output logic signed [rrs_pkg::OSUM_W-1:0]    o_turnaround_sum,
    output logic signed [rrs_pkg::OSUM_W-1:0]    o_wait_sum,
    output logic [rrs_pkg::TIME_W-1:0]           o_cpu_time
);

    localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CW = $clog2(MAX_PROCS + 1);
    localparam int BW = rrs_pkg::BURST_W;
    localparam int TW = rrs_pkg::TIME_W;
    localparam int DW = rrs_pkg::DIFF_W;
    localparam int SW = rrs_pkg::SUM_W;
    localparam int QW = rrs_pkg::QUANT_W;

    // per-process tables
    logic [BW-1:0]                  r_rem_mem   [MAX_PROCS];
    logic [BW-1:0]                  r_burst_mem [MAX_PROCS];
    logic [rrs_pkg::STAMP_W-1:0]    r_stamp_mem [MAX_PROCS];
    logic [TW-1:0]                  r_first_mem [MAX_PROCS];

    logic [BW-1:0]                  r_rem_rd;
    logic [BW-1:0]                  r_burst_rd;
    logic [rrs_pkg::STAMP_W-1:0]    r_stamp_rd;
    logic [TW-1:0]                  r_first_rd;

    logic [QW-1:0]          r_quantum;
    logic [MAX_PROCS-1:0]   r_started;
    logic [MAX_PROCS-1:0]   r_done;
    logic [CW-1:0]          r_loaded;
    logic [CW-1:0]          r_finished;
    logic [IW-1:0]          r_idx;
    logic [TW-1:0]          r_clock;
    logic [TW-1:0]          r_start;
    logic signed [DW-1:0]   r_turn;
    logic signed [DW-1:0]   r_wait;
    logic signed [SW-1:0]   r_tsum;
    logic signed [SW-1:0]   r_wsum;
    logic                   r_out_valid;

    logic [QW-1:0]          quant_eff;
    logic [BW-1:0]          slice;
    logic [BW-1:0]          rem_next;
    logic [IW-1:0]          idx_next;
    logic                   load_ok;
    logic signed [SW-1:0]   wsum_next;

    assign quant_eff = (r_quantum == '0) ? QW'(1) : r_quantum;
    assign slice     = (r_rem_rd < BW'(quant_eff)) ? r_rem_rd : BW'(quant_eff);
    assign rem_next  = r_rem_rd - slice;
    assign idx_next  = (CW'(r_idx) == r_loaded - CW'(1)) ? '0 : r_idx + IW'(1);
    assign load_ok   = (r_loaded < CW'(MAX_PROCS));
    assign wsum_next = r_wsum + {{(SW-DW){r_wait[DW-1]}}, r_wait};

    assign o_sts.cur_done  = r_done[r_idx];
    assign o_sts.rem_zero  = (rem_next == '0);
    assign o_sts.last_done = (r_finished == r_loaded);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;

    // table writes and registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && load_ok) begin
            r_rem_mem[r_loaded[IW-1:0]]   <= i_burst_time;
            r_burst_mem[r_loaded[IW-1:0]] <= i_burst_time;
            r_stamp_mem[r_loaded[IW-1:0]] <= i_arrival_stamp;
        end else if (i_cmd.exec) begin
            r_rem_mem[r_idx] <= rem_next;
        end
        if (i_cmd.exec && !r_started[r_idx]) begin
            r_first_mem[r_idx] <= r_clock;
        end
        r_rem_rd   <= r_rem_mem[r_idx];
        r_burst_rd <= r_burst_mem[r_idx];
        r_stamp_rd <= r_stamp_mem[r_idx];
        r_first_rd <= r_first_mem[r_idx];
    end

    // batch control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum   <= QW'(1);
            r_started   <= '0;
            r_done      <= '0;
            r_loaded    <= '0;
            r_finished  <= '0;
            r_idx       <= '0;
            r_clock     <= '0;
            r_tsum      <= '0;
            r_wsum      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_quantum <= i_cfg_wdata;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.clear) begin
                r_started  <= '0;
                r_done     <= '0;
                r_loaded   <= '0;
                r_finished <= '0;
                r_idx      <= '0;
                r_clock    <= '0;
                r_tsum     <= '0;
                r_wsum     <= '0;
            end else begin
                if (i_cmd.load && load_ok) begin
                    r_loaded <= r_loaded + CW'(1);
                end
                if (i_cmd.exec) begin
                    r_started[r_idx] <= 1'b1;
                    r_clock          <= r_clock + TW'(slice);
                end
                if (i_cmd.turn) begin
                    r_done[r_idx] <= 1'b1;
                    r_finished    <= r_finished + CW'(1);
                end
                if (i_cmd.wait_step) begin
                    r_tsum <= r_tsum + {{(SW-DW){r_turn[DW-1]}}, r_turn};
                end
                if (i_cmd.emit) begin
                    r_wsum <= wsum_next;
                end
                if (i_cmd.advance) begin
                    r_idx <= idx_next;
                end
            end
        end
    end

    // per-completion arithmetic and output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_start <= r_started[r_idx] ? r_first_rd : r_clock;
        end
        if (i_cmd.turn) begin
            r_turn <= {1'b0, r_clock} - DW'(r_stamp_rd);
        end
        if (i_cmd.wait_step) begin
            r_wait <= r_turn - DW'(r_burst_rd);
        end
        if (i_cmd.emit) begin
            o_proc_index   <= rrs_pkg::INDEX_W'(r_idx);
            o_start_time   <= r_start;
            o_finish_time  <= r_clock;
            o_turnaround   <= r_turn;
            o_wait_ticks   <= r_wait;
            o_final_result <= o_sts.last_done;
            if (o_sts.last_done) begin
                o_turnaround_sum <= r_tsum[rrs_pkg::OSUM_W-1:0];
                o_wait_sum       <= wsum_next[rrs_pkg::OSUM_W-1:0];
                o_cpu_time       <= r_clock;
            end else begin
                o_turnaround_sum <= '0;
                o_wait_sum       <= '0;
                o_cpu_time       <= '0;
            end
        end
    end

    `RRS_ASSERT(a_finished_le_loaded, r_finished <= r_loaded, "more completions than loaded processes")
    `RRS_ASSERT(a_done_implies_started, (r_done & ~r_started) == '0, "process finished without starting")
    `RRS_ASSERT_NEXT(a_clear_empties, i_cmd.emit && i_cmd.clear, r_loaded == '0 && r_done == '0, "batch not emptied after final item")

endmodule
